[src/linear_probe_hash_set_core_defines.svh]
// assertion macros for the linear probe hash set
// used by linear_probe_hash_set_core; needs nothing else
`ifndef LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH

// same-cycle implication
`define LPHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lphs_pkg.sv]
// shared types and constants of the linear probe hash set
// no dependencies
package lphs_pkg;

	localparam int DEPTH_DEF    = 256;
	localparam int KEY_BITS_DEF = 32;

	localparam int CAP_W   = 9;
	localparam int COUNT_W = 9;
	localparam int SLOT_W  = 8;
	localparam int HASH_W  = 32;
	localparam int KEYIN_W = 32;

	typedef logic [1:0] tag_t;
	localparam tag_t TAG_EMPTY = 2'd0;
	localparam tag_t TAG_TOMB  = 2'd1;
	localparam tag_t TAG_FULL  = 2'd2;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_FIND   = 2'd0;
	localparam mode_t MODE_INSERT = 2'd1;
	localparam mode_t MODE_REMOVE = 2'd2;
	localparam mode_t MODE_CLEAR  = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_ABSENT = 2'd1;
	localparam status_t ST_FULL   = 2'd2;

endpackage

[src/lphs_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module lphs_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/linear_probe_hash_set_core.sv]
// linear probing hash set: request control, modulo unit and probe sequencer
// depends on lphs_pkg, lphs_ram and linear_probe_hash_set_core_defines.svh
//
// channel   | dir | tdata (low bit up)              | tuser
// s_axis    | in  | key[31:0], hash_value[63:32]    | mode
// m_axis    | out | slot_index[7:0], entry_count[16:8], zero pad | status
// cfg       | in  | capacity on cfg_wdata when cfg_we | -
//
// an insert/find/remove first reduces the hash modulo capacity (4 bits a cycle),
// then probes one slot per cycle through the slot ram read port, then waits in the
// result state until the output register is free and returns to idle for the next request
// a find or remove on an empty set skips the modulo and probe cycles
// a clear, and the pass after reset, sweep all DEPTH slots one per cycle
// after reset no request is taken until that sweep is done
// a new request is taken while the previous result waits on m_axis
`include "linear_probe_hash_set_core_defines.svh"

module linear_probe_hash_set_core #(
	parameter int DEPTH    = lphs_pkg::DEPTH_DEF,
	parameter int KEY_BITS = lphs_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // key, hash_value
	input  logic [1:0]  s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // slot_index, entry_count, zero pad
	output logic [1:0]  m_axis_tuser,   // status
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = ((IW > lphs_pkg::CAP_W) ? IW : lphs_pkg::CAP_W) + 1;
	localparam int EW    = KEY_BITS + 2;
	localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_CLR   = 3'd4;
	localparam logic [2:0] S_RES   = 3'd5;

	logic [2:0]                  state_q;
	logic [lphs_pkg::CAP_W-1:0]  cap_q;
	logic [lphs_pkg::COUNT_W-1:0] cnt_q;
	lphs_pkg::mode_t             mode_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [lphs_pkg::HASH_W-1:0] hash_q;
	logic [lphs_pkg::CAP_W-1:0]  rem_q;
	logic [2:0]                  mcnt_q;
	logic [IW-1:0]               idx_q;
	logic [IW-1:0]               start_q;
	logic                        tomb_seen_q;
	logic [IW-1:0]               tomb_q;
	logic [IW-1:0]               clr_q;
	lphs_pkg::status_t           st_q;
	logic [lphs_pkg::SLOT_W-1:0] slot_q;
	logic                        m_valid_q;
	logic [23:0]                 m_data_q;
	lphs_pkg::status_t           m_user_q;

	logic                        ram_we;
	logic [IW-1:0]               ram_waddr;
	logic [EW-1:0]               ram_wdata;
	logic                        ram_re;
	logic [IW-1:0]               ram_raddr;
	logic [EW-1:0]               ram_rdata;

	logic [lphs_pkg::CAP_W-1:0]  rem_nxt;
	logic [IW-1:0]               rem_idx;
	lphs_pkg::tag_t              rd_tag;
	logic [KEY_BITS-1:0]         rd_key;
	logic                        hit;
	logic                        emp;
	logic [CW-1:0]               idx_inc;
	logic [IW-1:0]               idx_nxt;
	logic                        wrap;
	logic [IW-1:0]               chosen;
	logic                        accept;
	logic                        out_free;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// modulo step: four restoring bits per cycle
	always_comb begin
		logic [lphs_pkg::CAP_W:0] t;
		rem_nxt = rem_q;
		for (int i = 0; i < 4; i++) begin
			t = {rem_nxt, hash_q[lphs_pkg::HASH_W-1-i]};
			if (t >= {1'b0, cap_q}) begin
				t = t - {1'b0, cap_q};
			end
			rem_nxt = t[lphs_pkg::CAP_W-1:0];
		end
	end
	assign rem_idx = IW'(CW'(rem_nxt));

	// probe evaluation on the registered slot read
	assign rd_tag  = lphs_pkg::tag_t'(ram_rdata[EW-1 -: 2]);
	assign rd_key  = ram_rdata[KEY_BITS-1:0];
	assign hit     = (rd_tag == lphs_pkg::TAG_FULL) && (rd_key == key_q);
	assign emp     = (rd_tag == lphs_pkg::TAG_EMPTY);
	assign idx_inc = CW'(idx_q) + CW'(1);
	assign idx_nxt = (idx_inc == CW'(cap_q)) ? '0 : IW'(idx_inc);
	assign wrap    = (idx_nxt == start_q);
	assign chosen  = (!hit && tomb_seen_q) ? tomb_q : idx_q;

	// slot ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = {lphs_pkg::TAG_EMPTY, {KEY_BITS{1'b0}}};
		ram_re    = 1'b0;
		ram_raddr = idx_nxt;
		unique case (state_q)
			S_INIT, S_CLR: begin
				ram_we = 1'b1;
			end
			S_MOD: begin
				ram_re    = (mcnt_q == 3'd7);
				ram_raddr = rem_idx;
			end
			S_PROBE: begin
				if (hit || emp) begin
					if (mode_q == lphs_pkg::MODE_INSERT) begin
						ram_we    = 1'b1;
						ram_waddr = chosen;
						ram_wdata = {lphs_pkg::TAG_FULL, key_q};
					end else if (mode_q == lphs_pkg::MODE_REMOVE && hit) begin
						ram_we    = 1'b1;
						ram_waddr = idx_q;
						ram_wdata = {lphs_pkg::TAG_TOMB, key_q};
					end
				end else if (!wrap) begin
					ram_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	lphs_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// capacity register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lphs_pkg::CAP_W'(CAP_RST);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				cap_q <= lphs_pkg::CAP_W'(1);
			end else if (32'(cfg_wdata) > DEPTH) begin
				cap_q <= lphs_pkg::CAP_W'(DEPTH);
			end else begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			clr_q       <= '0;
			mcnt_q      <= '0;
			tomb_seen_q <= 1'b0;
			slot_q      <= '0;
			st_q        <= lphs_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_INIT, S_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(DEPTH - 1)) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_RES;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mcnt_q      <= '0;
						tomb_seen_q <= 1'b0;
						slot_q      <= '0;
						st_q        <= lphs_pkg::ST_OK;
						clr_q       <= '0;
						if (lphs_pkg::mode_t'(s_axis_tuser) == lphs_pkg::MODE_CLEAR) begin
							cnt_q   <= '0;
							state_q <= S_CLR;
						end else if (lphs_pkg::mode_t'(s_axis_tuser) != lphs_pkg::MODE_INSERT
							&& cnt_q == '0) begin
							st_q    <= lphs_pkg::ST_ABSENT;
							state_q <= S_RES;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd7) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (hit || emp) begin
						state_q <= S_RES;
						if (mode_q == lphs_pkg::MODE_INSERT) begin
							slot_q <= lphs_pkg::SLOT_W'(CW'(chosen));
							if (!hit) begin
								cnt_q <= cnt_q + lphs_pkg::COUNT_W'(1);
							end
						end else if (hit) begin
							slot_q <= lphs_pkg::SLOT_W'(CW'(idx_q));
							if (mode_q == lphs_pkg::MODE_REMOVE) begin
								cnt_q <= cnt_q - lphs_pkg::COUNT_W'(1);
							end
						end else begin
							st_q <= lphs_pkg::ST_ABSENT;
						end
					end else begin
						if (rd_tag == lphs_pkg::TAG_TOMB && !tomb_seen_q) begin
							tomb_seen_q <= 1'b1;
						end
						if (wrap) begin
							state_q <= S_RES;
							st_q <= (mode_q == lphs_pkg::MODE_INSERT) ?
								lphs_pkg::ST_FULL : lphs_pkg::ST_ABSENT;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, modulo and probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= lphs_pkg::mode_t'(s_axis_tuser);
			key_q  <= KEY_BITS'(s_axis_tdata[lphs_pkg::KEYIN_W-1:0]);
			hash_q <= s_axis_tdata[63:32];
			rem_q  <= '0;
		end else if (state_q == S_MOD) begin
			hash_q <= {hash_q[lphs_pkg::HASH_W-5:0], 4'd0};
			rem_q  <= rem_nxt;
			if (mcnt_q == 3'd7) begin
				idx_q   <= rem_idx;
				start_q <= rem_idx;
			end
		end else if (state_q == S_PROBE) begin
			idx_q <= idx_nxt;
			if (rd_tag == lphs_pkg::TAG_TOMB && !tomb_seen_q) begin
				tomb_q <= idx_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_RES && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			m_data_q <= {7'd0, cnt_q, slot_q};
			m_user_q <= st_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// checks
	`LPHS_ASSERT_NOW(a_probe_in_range, clk, arst_n, state_q == S_PROBE,
		CW'(idx_q) < CW'(cap_q), "probe index beyond capacity")
	`LPHS_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept,
		state_q != S_IDLE, "sequencer stayed idle after a request")
	`LPHS_ASSERT_NOW(a_no_write_when_reading, clk, arst_n, ram_we,
		!ram_re, "slot ram read and written in one cycle")
	`LPHS_ASSERT_NEXT(a_result_from_res, clk, arst_n, !(state_q == S_RES),
		!$rose(m_valid_q), "result raised outside the result state")

endmodule

[verif/linear_probe_hash_set_core_tb.sv]
// self-checking testbench for linear_probe_hash_set_core: find/insert/remove/clear
// requests against a behavioral set model, checked through a small scoreboard class
// depends on lphs_pkg and the core rtl
`timescale 1ns / 1ps

module linear_probe_hash_set_core_tb;

	localparam int DEPTH = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // key, hash_value
	logic [1:0]  s_axis_tuser = '0;   // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // slot_index, entry_count, zero pad
	logic [1:0]  m_axis_tuser;        // status
	logic        cfg_we = 1'b0;
	logic [8:0]  cfg_wdata = '0;

	typedef struct packed {
		lphs_pkg::status_t            status;
		logic [lphs_pkg::SLOT_W-1:0]  slot;
		logic [lphs_pkg::COUNT_W-1:0] count;
	} set_reply_t;

	// scoreboard: holds its own copy of the table and the queue of pending replies
	class set_scoreboard;
		lphs_pkg::tag_t tags [DEPTH];
		logic [31:0]    keys [DEPTH];
		int             occupied;
		int             cap;
		set_reply_t     pending [$];
		int             mismatches;
		int             replies_seen;

		function void init();
			foreach (tags[i]) tags[i] = lphs_pkg::TAG_EMPTY;
			occupied = 0;
			cap = DEPTH;
			mismatches = 0;
			replies_seen = 0;
		endfunction

		function void set_capacity(logic [8:0] v);
			cap = (v < 1) ? 1 : ((v > DEPTH) ? DEPTH : int'(v));
		endfunction

		// linear probe; returns 0 on wrap
		function bit probe_slot(logic [31:0] k, logic [31:0] h, output int slot);
			int idx;
			int start;
			bit have_tomb;
			int tomb;
			idx = int'(h % cap);
			start = idx;
			have_tomb = 0;
			tomb = 0;
			slot = 0;
			forever begin
				if (tags[idx] == lphs_pkg::TAG_EMPTY) begin
					slot = have_tomb ? tomb : idx;
					return 1;
				end else if (tags[idx] == lphs_pkg::TAG_TOMB) begin
					if (!have_tomb) begin
						have_tomb = 1;
						tomb = idx;
					end
				end else if (keys[idx] == k) begin
					slot = idx;
					return 1;
				end
				idx++;
				if (idx >= cap) idx = 0;
				if (idx == start) return 0;
			end
		endfunction

		// note an accepted request and queue its reply
		function void note_request(lphs_pkg::mode_t m, logic [31:0] k, logic [31:0] h);
			set_reply_t r;
			int s;
			bit hit;
			r.status = lphs_pkg::ST_OK;
			r.slot = '0;
			if (m == lphs_pkg::MODE_CLEAR) begin
				foreach (tags[i]) tags[i] = lphs_pkg::TAG_EMPTY;
				occupied = 0;
			end else if (m == lphs_pkg::MODE_INSERT) begin
				if (!probe_slot(k, h, s)) r.status = lphs_pkg::ST_FULL;
				else begin
					if (tags[s] != lphs_pkg::TAG_FULL) occupied++;
					tags[s] = lphs_pkg::TAG_FULL;
					keys[s] = k;
					r.slot = s[lphs_pkg::SLOT_W-1:0];
				end
			end else begin
				hit = (occupied != 0) && probe_slot(k, h, s);
				if (!hit || tags[s] != lphs_pkg::TAG_FULL) r.status = lphs_pkg::ST_ABSENT;
				else begin
					r.slot = s[lphs_pkg::SLOT_W-1:0];
					if (m == lphs_pkg::MODE_REMOVE) begin
						tags[s] = lphs_pkg::TAG_TOMB;
						occupied--;
					end
				end
			end
			r.count = occupied[lphs_pkg::COUNT_W-1:0];
			pending.push_back(r);
		endfunction

		// compare one reply with the oldest expectation
		function void check_reply(set_reply_t got);
			set_reply_t exp;
			replies_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected reply %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"reply mismatch: expected status %0d slot %0d count %0d,",
						" got status %0d slot %0d count %0d"},
						exp.status, exp.slot, exp.count, got.status, got.slot, got.count);
			end
		endfunction
	endclass

	set_scoreboard sb;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int n_sent = 0;
	logic [31:0] live_keys [$];

	linear_probe_hash_set_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// result side: sample at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_reply({m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8]});
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// drive one request transaction, with random idle before it
	task automatic send_request(lphs_pkg::mode_t m, logic [31:0] k, logic [31:0] h);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= m;
		s_axis_tdata <= {h, k};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(m, k, h);
		n_sent++;
		@(negedge clk);
	endtask

	// wait until every reply has arrived, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DEPTH + 20) @(negedge clk);
	endtask

	task automatic write_capacity(logic [8:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
	endtask

	// random request: mostly keys from a small pool so hits, removes and fills happen
	task automatic random_request(int key_pool);
		lphs_pkg::mode_t m;
		logic [31:0] k;
		logic [31:0] h;
		int r;
		r = $urandom_range(99);
		m = (r < 45) ? lphs_pkg::MODE_INSERT : (r < 70) ? lphs_pkg::MODE_FIND :
			(r < 98) ? lphs_pkg::MODE_REMOVE : lphs_pkg::MODE_CLEAR;
		if ($urandom_range(9) < 8 && live_keys.size() != 0 && m != lphs_pkg::MODE_INSERT)
			k = live_keys[$urandom_range(live_keys.size() - 1)];
		else if ($urandom_range(9) < 8)
			k = $urandom_range(key_pool - 1);
		else
			k = $urandom;
		// hash tied to the key most of the time so finds of a stored key succeed
		h = ($urandom_range(9) < 8) ? k * 32'h9e3779b1 : $urandom;
		if (m == lphs_pkg::MODE_INSERT) live_keys.push_back(k);
		if (live_keys.size() > 64) void'(live_keys.pop_front());
		send_request(m, k, h);
	endtask

	logic [8:0] cap_list [6] = '{9'd4, 9'd1, 9'd0, 9'd17, 9'd300, 9'd256};

	initial begin
		sb = new();
		sb.init();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty set, extremes, every mode, full table, wrap with tombstones
		send_request(lphs_pkg::MODE_FIND, 32'hffff_ffff, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_REMOVE, 32'h0, 32'h0);
		send_request(lphs_pkg::MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_INSERT, 32'h0, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_FIND, 32'h0, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_FIND, 32'h1234, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_FIND, 32'h0, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_INSERT, 32'haaaa_5555, 32'hffff_ffff);
		send_request(lphs_pkg::MODE_CLEAR, 32'h5555_aaaa, 32'h0);
		write_capacity(9'd2);
		send_request(lphs_pkg::MODE_INSERT, 32'd7, 32'd0);
		send_request(lphs_pkg::MODE_INSERT, 32'd8, 32'd1);
		send_request(lphs_pkg::MODE_INSERT, 32'd9, 32'd0);
		send_request(lphs_pkg::MODE_REMOVE, 32'd7, 32'd0);
		send_request(lphs_pkg::MODE_INSERT, 32'd9, 32'd1);
		send_request(lphs_pkg::MODE_FIND, 32'd9, 32'd1);
		send_request(lphs_pkg::MODE_FIND, 32'd8, 32'd0);
		send_request(lphs_pkg::MODE_CLEAR, 32'd0, 32'd0);

		// random phases over several capacities and idling patterns
		for (int ph = 0; ph < 6; ph++) begin
			write_capacity(cap_list[ph]);
			case (ph % 3)
				0: begin src_idle_pct = 37; dst_idle_pct = 60; end
				1: begin src_idle_pct = 60; dst_idle_pct = 37; end
				default: begin src_idle_pct = 0; dst_idle_pct = 0; end
			endcase
			live_keys.delete();
			repeat (325) random_request((ph == 5) ? 400 : 40);
		end
		drain();

		$display("sent %0d requests, checked %0d replies over capacities 1 to 256",
			n_sent, sb.replies_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[linear_probe_hash_set_core] OK");
		else
			$display("[linear_probe_hash_set_core] ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("[linear_probe_hash_set_core] ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/lphs_pkg.sv
src/lphs_ram.sv
src/linear_probe_hash_set_core.sv
verif/linear_probe_hash_set_core_tb.sv
